### sv/vptw_pkg.sv
// Shared types, codes, constants and helpers of the vertex projection block.
package vptw_pkg;

    // Default number of fraction bits of the fixed-point format.
    localparam int FRAC_BITS_DEFAULT = 16;

    // Widths fixed by the item and register definitions.
    localparam int DATA_W    = 32;
    localparam int VP_W      = 15;
    localparam int CFG_IDX_W = 2;

    // Reset values of the viewport size registers.
    localparam logic [VP_W-1:0] VP_WIDTH_RESET  = VP_W'(640);
    localparam logic [VP_W-1:0] VP_HEIGHT_RESET = VP_W'(480);

    // Operation codes of an input item.
    localparam logic [1:0] OP_WRITE_MODEL = 2'd0;
    localparam logic [1:0] OP_WRITE_PROJ  = 2'd1;
    localparam logic [1:0] OP_PROJECT     = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_VIEWPORT_X      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEWPORT_Y      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEWPORT_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEWPORT_HEIGHT = 2'd3;

    // Two matrix passes of four rows by four columns.
    localparam int MAC_STEPS = 32;
    localparam int STEP_W    = $clog2(MAC_STEPS);

    // Quotient bits retired per divider cycle.
    localparam int DIV_BITS = 4;

    // Width of the common saturation input.
    localparam int SAT_W = 72;
    localparam logic signed [SAT_W-1:0] SAT_HI = 72'sd2147483647;
    localparam logic signed [SAT_W-1:0] SAT_LO = -72'sd2147483648;

    typedef struct packed {
        logic [1:0]               operation;
        logic [3:0]               entry_index;
        logic signed [DATA_W-1:0] entry_value;
        logic signed [DATA_W-1:0] obj_x;
        logic signed [DATA_W-1:0] obj_y;
        logic signed [DATA_W-1:0] obj_z;
    } t_in_item;

    typedef struct packed {
        logic                     ok;
        logic signed [DATA_W-1:0] win_x;
        logic signed [DATA_W-1:0] win_y;
        logic signed [DATA_W-1:0] win_z;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_CHECK,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_VIEW_X,
        ST_VIEW_Y,
        ST_VIEW_END,
        ST_DONE
    } t_state;

    // Position of a product in the multiply-accumulate pipeline.
    typedef struct packed {
        logic       pass;
        logic [1:0] row;
        logic [1:0] col;
    } t_mac_tag;

    function automatic logic signed [DATA_W-1:0] f_sat32(input logic signed [SAT_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[DATA_W-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[DATA_W-1:0];
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

### sv/vertex_project_to_window.sv
// Data are signed fixed point, Q16.16 by default; matrix writes give no result.
// One projection at a time: 32 multiply-accumulates on the single 33x33 multiplier, then,
// unless the projected w is zero, three divisions by w on the radix-16 divider; the input
// is stalled until the result is taken into the output register.
// Reset (synchronous, active low) sets both matrices to identity and the viewport to
// origin 0,0 with size 640 by 480, and empties the output register.
module vertex_project_to_window
    import vptw_pkg::*;
#(
    parameter int FRACTION_BITS = FRAC_BITS_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [VP_W-1:0]       i_cfg_data
);

    localparam int ACC_W  = 2 * (DATA_W + 1);
    localparam logic signed [DATA_W-1:0] ONE32 = 32'sd1 <<< FRACTION_BITS;
    localparam logic signed [DATA_W:0]   ONE33 = 33'sd1 <<< FRACTION_BITS;

    t_state r_state;
    t_state n_state;

    logic signed [DATA_W-1:0] r_model [16];
    logic signed [DATA_W-1:0] r_proj  [16];
    logic signed [VP_W-1:0]   r_vp_x;
    logic signed [VP_W-1:0]   r_vp_y;
    logic [VP_W-1:0]          r_vp_w;
    logic [VP_W-1:0]          r_vp_h;

    logic signed [DATA_W-1:0] r_obj  [3];
    logic signed [DATA_W-1:0] r_eye  [4];
    logic signed [DATA_W-1:0] r_clip [4];
    logic signed [DATA_W-1:0] r_ndc  [3];

    logic [STEP_W-1:0]        r_step;
    logic signed [ACC_W-1:0]  r_prod;
    logic                     r_prod_vld;
    t_mac_tag                 r_tag;
    logic signed [ACC_W-1:0]  r_acc;
    logic [1:0]               r_div_idx;

    logic                     r_ok;
    logic signed [DATA_W-1:0] r_win_x;
    logic signed [DATA_W-1:0] r_win_y;
    logic signed [DATA_W-1:0] r_win_z;
    t_out_item                r_out;
    logic                     r_out_vld;

    logic                     w_in_acc;
    logic                     w_out_free;
    logic                     w_div_start;
    logic                     w_div_done;
    logic signed [DATA_W-1:0] w_div_quot;
    logic                     w_pass;
    logic [1:0]               w_row;
    logic [1:0]               w_col;
    logic signed [DATA_W-1:0] w_mat_entry;
    logic signed [DATA_W:0]   w_src;
    logic signed [DATA_W:0]   w_mul_a;
    logic signed [DATA_W:0]   w_mul_b;
    logic signed [ACC_W-1:0]  w_term;
    logic signed [ACC_W-1:0]  w_acc_base;
    logic signed [ACC_W-1:0]  w_acc_sum;
    logic signed [DATA_W-1:0] w_acc_sat;
    logic signed [ACC_W-1:0]  w_prod_rnd;
    logic signed [ACC_W-1:0]  w_half;
    logic signed [VP_W-1:0]   w_vp_org;
    logic signed [SAT_W-1:0]  w_vp_base;
    logic signed [SAT_W-1:0]  w_view_sum;
    logic signed [DATA_W:0]   w_z_one;
    logic signed [DATA_W:0]   w_z_rnd;
    logic signed [DATA_W:0]   w_z_half;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_vld || !i_out_stall;

    assign w_pass      = r_step[STEP_W-1];
    assign w_row       = r_step[3:2];
    assign w_col       = r_step[1:0];
    assign w_mat_entry = w_pass ? r_proj[{w_col, w_row}] : r_model[{w_col, w_row}];

    always_comb begin
        if (w_pass) begin
            w_src = {r_eye[w_col][DATA_W-1], r_eye[w_col]};
        end else if (w_col == 2'd3) begin
            w_src = ONE33;
        end else begin
            w_src = {r_obj[w_col][DATA_W-1], r_obj[w_col]};
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc && i_in_data.operation == OP_PROJECT) begin
                    n_state = ST_MAC;
                end
            end
            ST_MAC: begin
                if (r_step == STEP_W'(MAC_STEPS - 1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: n_state = ST_CHECK;
            ST_CHECK: begin
                n_state = (r_clip[3] == '0) ? ST_DONE : ST_DIV_GO;
            end
            ST_DIV_GO: n_state = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (w_div_done) begin
                    n_state = (r_div_idx == 2'd2) ? ST_VIEW_X : ST_DIV_GO;
                end
            end
            ST_VIEW_X:   n_state = ST_VIEW_Y;
            ST_VIEW_Y:   n_state = ST_VIEW_END;
            ST_VIEW_END: n_state = ST_DONE;
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: stall, divider start and multiplier operands.
    always_comb begin
        o_in_stall  = (r_state != ST_IDLE);
        w_div_start = (r_state == ST_DIV_GO);
        w_mul_a     = '0;
        w_mul_b     = '0;
        case (r_state)
            ST_MAC: begin
                w_mul_a = {w_mat_entry[DATA_W-1], w_mat_entry};
                w_mul_b = w_src;
            end
            ST_VIEW_X: begin
                w_mul_a = ONE33 + $signed({r_ndc[0][DATA_W-1], r_ndc[0]});
                w_mul_b = $signed({{(DATA_W+1-VP_W){1'b0}}, r_vp_w});
            end
            ST_VIEW_Y: begin
                w_mul_a = ONE33 + $signed({r_ndc[1][DATA_W-1], r_ndc[1]});
                w_mul_b = $signed({{(DATA_W+1-VP_W){1'b0}}, r_vp_h});
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // Accumulate one truncated product per cycle; the row sum saturates on its last column.
    always_comb begin
        w_term     = r_prod >>> FRACTION_BITS;
        w_acc_base = (r_tag.col == 2'd0) ? $signed({ACC_W{1'b0}}) : r_acc;
        w_acc_sum  = w_acc_base + w_term;
        w_acc_sat  = f_sat32($signed({{(SAT_W-ACC_W){w_acc_sum[ACC_W-1]}}, w_acc_sum}));
    end

    // Viewport mapping; halving truncates toward zero.
    always_comb begin
        w_prod_rnd = r_prod + $signed({{(ACC_W-1){1'b0}}, r_prod[ACC_W-1]});
        w_half     = w_prod_rnd >>> 1;
        w_vp_org   = (r_state == ST_VIEW_Y) ? r_vp_x : r_vp_y;
        w_vp_base  = $signed({{(SAT_W-VP_W){w_vp_org[VP_W-1]}}, w_vp_org}) <<< FRACTION_BITS;
        w_view_sum = w_vp_base + $signed({{(SAT_W-ACC_W){w_half[ACC_W-1]}}, w_half});
        w_z_one    = ONE33 + $signed({r_ndc[2][DATA_W-1], r_ndc[2]});
        w_z_rnd    = w_z_one + $signed({{DATA_W{1'b0}}, w_z_one[DATA_W]});
        w_z_half   = w_z_rnd >>> 1;
    end

    vptw_div #(
        .FRAC_BITS (FRACTION_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_clip[r_div_idx]),
        .i_den   (r_clip[3]),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    // Control state, matrices and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_step     <= '0;
            r_prod_vld <= 1'b0;
            r_out_vld  <= 1'b0;
            r_vp_x     <= '0;
            r_vp_y     <= '0;
            r_vp_w     <= VP_WIDTH_RESET;
            r_vp_h     <= VP_HEIGHT_RESET;
            for (int i = 0; i < 16; i++) begin
                r_model[i] <= (i == 0 || i == 5 || i == 10 || i == 15) ? ONE32 : '0;
                r_proj[i]  <= (i == 0 || i == 5 || i == 10 || i == 15) ? ONE32 : '0;
            end
        end else begin
            r_state    <= n_state;
            r_prod_vld <= (r_state == ST_MAC);
            if (r_state == ST_MAC) begin
                r_step <= r_step + STEP_W'(1);
            end else begin
                r_step <= '0;
            end
            if (w_in_acc && i_in_data.operation == OP_WRITE_MODEL) begin
                r_model[i_in_data.entry_index] <= i_in_data.entry_value;
            end
            if (w_in_acc && i_in_data.operation == OP_WRITE_PROJ) begin
                r_proj[i_in_data.entry_index] <= i_in_data.entry_value;
            end
            if (r_state == ST_DONE && w_out_free) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_VIEWPORT_X:      r_vp_x <= i_cfg_data;
                    CFG_VIEWPORT_Y:      r_vp_y <= i_cfg_data;
                    CFG_VIEWPORT_WIDTH:  r_vp_w <= i_cfg_data;
                    CFG_VIEWPORT_HEIGHT: r_vp_h <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
        r_tag  <= '{pass: w_pass, row: w_row, col: w_col};
        if (w_in_acc) begin
            r_obj[0] <= i_in_data.obj_x;
            r_obj[1] <= i_in_data.obj_y;
            r_obj[2] <= i_in_data.obj_z;
        end
        if (r_prod_vld) begin
            r_acc <= w_acc_sum;
            if (r_tag.col == 2'd3) begin
                if (r_tag.pass) begin
                    r_clip[r_tag.row] <= w_acc_sat;
                end else begin
                    r_eye[r_tag.row] <= w_acc_sat;
                end
            end
        end
        if (r_state == ST_CHECK) begin
            r_div_idx <= 2'd0;
            r_ok      <= (r_clip[3] != '0);
            r_win_x   <= '0;
            r_win_y   <= '0;
            r_win_z   <= '0;
        end
        if (r_state == ST_DIV_WAIT && w_div_done) begin
            r_ndc[r_div_idx] <= w_div_quot;
            r_div_idx        <= r_div_idx + 2'd1;
        end
        if (r_state == ST_VIEW_Y) begin
            r_win_x <= f_sat32(w_view_sum);
        end
        if (r_state == ST_VIEW_END) begin
            r_win_y <= f_sat32(w_view_sum);
            r_win_z <= w_z_half[DATA_W-1:0];
        end
        if (r_state == ST_DONE && w_out_free) begin
            r_out <= '{ok: r_ok, win_x: r_win_x, win_y: r_win_y, win_z: r_win_z};
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

### sv/vptw_div.sv
// Iterative signed divider: (num * 2^FRAC_BITS) / den, truncated toward zero, saturated.
module vptw_div
    import vptw_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [DATA_W-1:0] i_num,
    input  logic signed [DATA_W-1:0] i_den,
    output logic                     o_done,
    output logic signed [DATA_W-1:0] o_quot
);

    localparam int NUM_W = DATA_W + FRAC_BITS;
    localparam int STEPS = (NUM_W + DIV_BITS - 1) / DIV_BITS;
    localparam int QW    = STEPS * DIV_BITS;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [QW-1:0]     r_quo;
    logic [DATA_W:0]   r_rem;
    logic [DATA_W-1:0] r_den;
    logic              r_neg;

    logic signed [DATA_W:0] w_num_ext;
    logic signed [DATA_W:0] w_den_ext;
    logic [DATA_W:0]        w_num_mag;
    logic [DATA_W:0]        w_den_mag;
    logic [QW-1:0]          w_quo;
    logic [DATA_W:0]        w_rem;
    logic signed [QW:0]     w_q_signed;

    assign w_num_ext = {i_num[DATA_W-1], i_num};
    assign w_den_ext = {i_den[DATA_W-1], i_den};
    assign w_num_mag = i_num[DATA_W-1] ? -w_num_ext : w_num_ext;
    assign w_den_mag = i_den[DATA_W-1] ? -w_den_ext : w_den_ext;

    // Restoring division, several quotient bits per cycle.
    always_comb begin
        w_rem = r_rem;
        w_quo = r_quo;
        for (int j = 0; j < DIV_BITS; j++) begin
            w_rem = {w_rem[DATA_W-1:0], w_quo[QW-1]};
            w_quo = {w_quo[QW-2:0], 1'b0};
            if (w_rem >= {1'b0, r_den}) begin
                w_rem    = w_rem - {1'b0, r_den};
                w_quo[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= QW'({w_num_mag[DATA_W-1:0], {FRAC_BITS{1'b0}}});
            r_rem <= '0;
            r_den <= w_den_mag[DATA_W-1:0];
            r_neg <= i_num[DATA_W-1] ^ i_den[DATA_W-1];
        end else if (r_busy) begin
            r_quo <= w_quo;
            r_rem <= w_rem;
        end
    end

    assign w_q_signed = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
    assign o_quot     = f_sat32($signed({{(SAT_W-QW-1){w_q_signed[QW]}}, w_q_signed}));
    assign o_done     = r_done;

endmodule

### sv/vptw_checker.sv
// Port-level checks of the vertex projection block and their binding to it.
module vptw_checker
    import vptw_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_stall,
    input t_in_item             i_in_data,
    input logic                 i_out_valid,
    input logic                 i_out_stall,
    input t_out_item            i_out_data,
    input logic                 i_cfg_we,
    input logic [CFG_IDX_W-1:0] i_cfg_index,
    input logic [VP_W-1:0]      i_cfg_data
);

    logic w_in_xfer;
    logic w_cfg_seen;

    assign w_in_xfer  = i_in_valid && !i_in_stall;
    assign w_cfg_seen = i_cfg_we && (i_cfg_index == CFG_VIEWPORT_X || i_cfg_data != '0);

    // A result waiting on a stalled sink holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_out_data))
        else $error("result changed while stalled");

    // A projection occupies the block for the following cycle at least.
    a_project_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer && i_in_data.operation == OP_PROJECT |=> i_in_stall)
        else $error("input not stalled after a projection transfer");

    // Matrix writes and the unused code finish in the cycle of their transfer.
    a_write_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer && i_in_data.operation != OP_PROJECT |=> !i_in_stall)
        else $error("input stalled after a write transfer");

    // A degenerate w yields all-zero coordinates.
    a_zero_w: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.ok |->
            i_out_data.win_x == '0 && i_out_data.win_y == '0 && i_out_data.win_z == '0)
        else $error("coordinates not zero on a failed projection");

    // A new result only appears at the end of a projection, while the input is stalled.
    a_result_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n || w_cfg_seen)
        $rose(i_out_valid) |-> $past(i_in_stall))
        else $error("result appeared without a projection in progress");

endmodule

bind vertex_project_to_window vptw_checker u_vptw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_index (i_cfg_index),
    .i_cfg_data  (i_cfg_data)
);
